>>> hdl/bap_pkg.sv
// Shared definitions for the bit activity profiler.
// Holds the item modes, parameter defaults and the controller/datapath structs.
// No dependencies.
package bap_pkg;

   localparam int MAX_BITS_DEFAULT    = 256;
   localparam int COUNT_WIDTH_DEFAULT = 16;

   localparam int BIT_COUNT_WIDTH = 9;
   localparam logic [BIT_COUNT_WIDTH-1:0] BIT_COUNT_RESET = 9'd256;

   localparam int LANES = 8;

   localparam logic [1:0] MODE_FRAME = 2'd0;
   localparam logic [1:0] MODE_QUERY = 2'd1;
   localparam logic [1:0] MODE_CLEAR = 2'd2;

   localparam logic [1:0] CLASS_STATIC  = 2'd0;
   localparam logic [1:0] CLASS_SLOW    = 2'd1;
   localparam logic [1:0] CLASS_COUNTER = 2'd2;

   typedef struct packed {
      logic load;
      logic sweep_start;
      logic sweep;
      logic commit;
   } bap_cmd_type;

   typedef struct packed {
      logic req_clear;
      logic item_query;
      logic rsp_free;
      logic sweep_last;
   } bap_status_type;

endpackage

>>> hdl/bap_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module bap_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/bap_ctrl.sv
// Controller state machine of the bit activity profiler.
// Sequences the clearing pass, item acceptance and write-back; uses bap_pkg.
module bap_ctrl
   import bap_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_tvalid,
   output logic           req_tready,
   input  bap_status_type status,
   output bap_cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_CLEAR  = 3'b001,
      ST_IDLE   = 3'b010,
      ST_UPDATE = 3'b100
   } bap_state_type;

   bap_state_type state_ff, state_in;
   logic          accept;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      cmd.load        = accept;
      cmd.sweep_start = accept && status.req_clear;
      cmd.sweep       = (state_ff == ST_CLEAR);
      cmd.commit      = (state_ff == ST_UPDATE) && (!status.item_query || status.rsp_free);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (status.sweep_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = status.req_clear ? ST_CLEAR : ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (cmd.commit) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> hdl/bap_datapath.sv
// Datapath of the bit activity profiler: statistics RAM, lane update, classifier.
// Uses bap_pkg and instantiates bap_ram.
module bap_datapath
   import bap_pkg::*;
#(
   parameter int MAX_BITS    = MAX_BITS_DEFAULT,
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [1:0]                 req_tuser,
   input  logic [23:0]                req_tdata,
   input  logic                       req_tlast,
   input  logic                       rsp_tready,
   output logic                       rsp_tvalid,
   output logic [55:0]                rsp_tdata,
   input  logic                       csr_wr_en,
   input  logic [BIT_COUNT_WIDTH-1:0] csr_wr_data,
   input  bap_cmd_type                cmd,
   output bap_status_type             status
);

   localparam int CW     = COUNT_WIDTH;
   localparam int ROWS   = (MAX_BITS + LANES - 1) / LANES;
   localparam int AW     = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int LANE_W = 2 * CW + 3;
   localparam int ROW_W  = LANES * LANE_W;
   localparam int P_PREV = 2 * CW;
   localparam int P_SEEN0 = 2 * CW + 1;
   localparam int P_SEEN1 = 2 * CW + 2;
   localparam logic [CW-1:0] CNT_MAX = {CW{1'b1}};

   function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
      return (v == CNT_MAX) ? v : v + 1'b1;
   endfunction

   logic [BIT_COUNT_WIDTH-1:0] bit_count_ff;
   logic [CW-1:0]              frames_ff, frames_in;
   logic [AW-1:0]              sweep_ff, sweep_in;
   logic [1:0]                 mode_ff;
   logic [7:0]                 byte_ff;
   logic [4:0]                 row_ff;
   logic                       eof_ff;
   logic [7:0]                 qbit_ff;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [55:0]                rsp_data_ff, rsp_data_in;

   logic [1:0]       req_mode;
   logic [7:0]       req_byte;
   logic [4:0]       req_row;
   logic [7:0]       req_qbit;
   logic             ram_wr_en;
   logic [AW-1:0]    ram_wr_addr, ram_rd_addr;
   logic [ROW_W-1:0] ram_wr_data, ram_rd_data, row_upd;

   logic [LANE_W-1:0] qlane;
   logic              q_in_range;
   logic [1:0]        distinct, cls;
   logic [CW-1:0]     q_ones, q_chg;
   logic [CW+2:0]     chg_x5, frames_x4;

   assign req_mode = req_tuser;
   assign req_byte = req_tdata[7:0];
   assign req_row  = req_tdata[12:8];
   assign req_qbit = req_tdata[20:13];

   always_comb begin
      status.req_clear  = (req_mode == MODE_CLEAR);
      status.item_query = (mode_ff == MODE_QUERY);
      status.rsp_free   = !rsp_valid_ff || rsp_tready;
      status.sweep_last = (sweep_ff == AW'(ROWS - 1));
   end

   // Position is profiled when below both bit_count and the storage depth.
   function automatic logic in_range(input logic [7:0] pos, input logic [8:0] lim);
      return ({1'b0, pos} < lim) && (32'(pos) < MAX_BITS);
   endfunction

   // Read-modify-write of the eight lanes covered by one frame byte.
   always_comb begin
      row_upd = ram_rd_data;
      for (int k = 0; k < LANES; k++) begin
         logic [LANE_W-1:0] ln;
         logic              v;
         logic [7:0]        pos;
         ln  = ram_rd_data[k*LANE_W +: LANE_W];
         v   = byte_ff[LANES-1-k];
         pos = {row_ff, 3'(k)};
         if (in_range(pos, bit_count_ff)) begin
            if (v) begin
               ln[CW-1:0]  = sat_inc(ln[CW-1:0]);
               ln[P_SEEN1] = 1'b1;
            end else begin
               ln[P_SEEN0] = 1'b1;
            end
            if ((frames_ff != '0) && (v != ln[P_PREV])) begin
               ln[2*CW-1:CW] = sat_inc(ln[2*CW-1:CW]);
            end
            ln[P_PREV] = v;
         end
         row_upd[k*LANE_W +: LANE_W] = ln;
      end
   end

   assign ram_wr_en   = cmd.sweep || (cmd.commit && (mode_ff == MODE_FRAME));
   assign ram_wr_addr = cmd.sweep ? sweep_ff : AW'(row_ff);
   assign ram_wr_data = cmd.sweep ? '0 : row_upd;
   assign ram_rd_addr = (req_mode == MODE_QUERY) ? AW'(req_qbit[7:3]) : AW'(req_row);

   bap_ram #(
      .WIDTH (ROW_W),
      .DEPTH (ROWS)
   ) u_stats_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (cmd.load),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Query: pick the lane, then classify.
   always_comb begin
      qlane      = ram_rd_data[qbit_ff[2:0]*LANE_W +: LANE_W];
      q_in_range = in_range(qbit_ff, bit_count_ff);
      q_ones     = q_in_range ? qlane[CW-1:0] : '0;
      q_chg      = q_in_range ? qlane[2*CW-1:CW] : '0;
      distinct   = 2'd0;
      if (q_in_range && (frames_ff != '0)) begin
         distinct = {1'b0, qlane[P_SEEN0]} + {1'b0, qlane[P_SEEN1]};
      end
      chg_x5    = {1'b0, q_chg, 2'b00} + {3'b000, q_chg};
      frames_x4 = {1'b0, frames_ff - 1'b1, 2'b00};
      cls       = CLASS_STATIC;
      if (distinct == 2'd2) begin
         cls = (chg_x5 >= frames_x4) ? CLASS_COUNTER : CLASS_SLOW;
      end
      rsp_data_in = {4'd0, 16'(frames_ff), 16'(q_chg), 16'(q_ones), distinct, cls};
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit && (mode_ff == MODE_QUERY)) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_comb begin
      frames_in = frames_ff;
      if (cmd.sweep_start) begin
         frames_in = '0;
      end else if (cmd.commit && (mode_ff == MODE_FRAME) && eof_ff) begin
         frames_in = sat_inc(frames_ff);
      end
   end

   always_comb begin
      sweep_in = sweep_ff;
      if (cmd.sweep_start) begin
         sweep_in = '0;
      end else if (cmd.sweep) begin
         sweep_in = sweep_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_count_ff <= BIT_COUNT_RESET;
         frames_ff    <= '0;
         sweep_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            bit_count_ff <= csr_wr_data;
         end
         frames_ff    <= frames_in;
         sweep_ff     <= sweep_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff <= req_mode;
         byte_ff <= req_byte;
         row_ff  <= req_row;
         eof_ff  <= req_tlast;
         qbit_ff <= req_qbit;
      end
      if (cmd.commit && (mode_ff == MODE_QUERY)) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

>>> hdl/bit_activity_profiler.sv
// Top level of the bit activity profiler.
// Joins bap_ctrl and bap_datapath; uses bap_pkg.
//
// The profiler watches a stream of captured frames, one byte per transaction with the most
// significant bit at the lowest bit position, and keeps for every position a count of ones, a
// count of value changes between consecutive frames and marks of whether zero and one were
// seen. A query transaction returns the class of one position (static, slow changing or counter
// like, the latter when five times the change count reaches four times the frame count less
// one) together with its counts and the saturating frame count; a clear transaction restarts the
// analysis. Statistics live in one RAM row per byte position, eight lanes wide, so a frame byte
// is a single read-modify-write of one row. For every frame byte, query or ignored transaction
// the row is read in the accept cycle and written back, or the response loaded, in the update
// state that follows, and only then is a new transaction accepted. A query waits there while an
// earlier response has not been taken. A clear transaction, and also reset, starts a clearing
// pass that writes one row a cycle, so the block accepts nothing until every row is cleared;
// configuration writes are taken at any time. Only configure bit_count while no transaction is
// in progress.
module bit_activity_profiler
   import bap_pkg::*;
#(
   parameter int MAX_BITS    = MAX_BITS_DEFAULT,
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   // Request channel.
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [23:0]                req_tdata,  // frame_byte[7:0], byte_index[12:8],
                                                  // query_bit[20:13], zero fill
   input  logic [1:0]                 req_tuser,  // mode[1:0]
   input  logic                       req_tlast,  // end_of_frame
   // Response channel.
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [55:0]                rsp_tdata,  // bit_class[1:0], distinct_values[3:2],
                                                  // ones_count[19:4], change_count[35:20],
                                                  // frames_seen[51:36], zero fill
   // Configuration port for bit_count.
   input  logic                       csr_wr_en,
   input  logic [BIT_COUNT_WIDTH-1:0] csr_wr_data
);

   // Rows of the statistics RAM, which is also the number of rows a clearing pass writes.
   localparam int SWEEP_ROWS = (MAX_BITS + LANES - 1) / LANES;

   bap_cmd_type    cmd;
   bap_status_type status;

   // The controller only sequences; all statistics and the response register sit in the
   // datapath.
   bap_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   bap_datapath #(
      .MAX_BITS    (MAX_BITS),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_tuser   (req_tuser),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tready  (rsp_tready),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .status      (status)
   );

   // One transaction at a time: the cycle after an accept never accepts again.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted in consecutive cycles");

   // A clear transaction starts the clearing pass, which blocks requests while it writes every row.
   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && (req_tuser == MODE_CLEAR)) |=> (!req_tready) [*SWEEP_ROWS])
      else $error("request accepted during clearing pass");

   // A response only appears after the update state of a query, never from the idle state.
   a_rsp_after_update: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("response raised without a pending query");

endmodule
